[rtl/sma_pkg.sv]
package sma_pkg;

    typedef enum logic [4:0] {
        OP_PUSH   = 5'd0,
        OP_ADD    = 5'd1,
        OP_SUB    = 5'd2,
        OP_MUL    = 5'd3,
        OP_DIV    = 5'd4,
        OP_MOD    = 5'd5,
        OP_NEG    = 5'd6,
        OP_EMIT   = 5'd7,
        OP_DUP    = 5'd8,
        OP_DROP   = 5'd9,
        OP_SWAP   = 5'd10,
        OP_ROT    = 5'd11,
        OP_LT     = 5'd12,
        OP_LE     = 5'd13,
        OP_GT     = 5'd14,
        OP_GE     = 5'd15,
        OP_EQ     = 5'd16,
        OP_NE     = 5'd17,
        OP_AND    = 5'd18,
        OP_OR     = 5'd19,
        OP_NOT    = 5'd20,
        OP_DEFINE = 5'd21,
        OP_FETCH  = 5'd22,
        OP_STORE  = 5'd23
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZ    = 3'd3,
        ST_DEFINED = 3'd4,
        ST_UNDEF   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ3,
        S_EXEC,
        S_DIV,
        S_WRITE2,
        S_WRITE3
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;

endpackage

[rtl/sma_ram.sv]
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sma_div.sv]
// Signed restoring divider, one quotient bit per cycle, then a registered result strobe.
module sma_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sma_pkg::div_req_t   req,
    output sma_pkg::div_rsp_t   rsp
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic        mod_reg, mod_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        mod_next  = mod_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        rem_sh    = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, rem_sh} - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            quo_next  = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
            dvs_next  = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
            rem_next  = 32'd0;
            qneg_next = req.dividend[31] ^ req.divisor[31];
            rneg_next = req.dividend[31];
            mod_next  = req.is_mod;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (mod_reg)
                begin
                    res_next = rneg_reg ? 32'd0 - rem_reg : rem_reg;
                end
                else
                begin
                    res_next = qneg_reg ? 32'd0 - quo_reg : quo_reg;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        mod_reg  <= mod_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[rtl/stack_machine_alu.sv]
// Stack machine: one operation per start pulse, one result strobe (done) per operation.
// Most operations read the stack RAM, execute, and then show the result; rot reads
// three entries and writes three back through the single RAM write port, swap writes
// two back, and div/mod wait for the bit-serial divider. busy is high from the accepted
// start until done; a new start is taken in the cycle done is shown. The receiver
// cannot stall: each emit is shown only in the done cycle.
module stack_machine_alu #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         opcode,
    input  logic signed [31:0] immediate,
    input  logic [3:0]         var_index,
    output logic               done,
    output logic [2:0]         status,
    output logic               emit_valid,
    output logic signed [31:0] emit_value,
    output logic [6:0]         stack_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    sma_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [4:0]    op_reg, op_next;
    logic [31:0]   imm_reg, imm_next;
    logic [VW-1:0] vi_reg, vi_next;
    logic [31:0]   a_reg, a_next;   // second from top
    logic [31:0]   b_reg, b_next;   // top
    logic [31:0]   c_reg, c_next;   // third from top (rot)
    logic [VAR_COUNT-1:0] def_reg, def_next;
    logic          done_reg, done_next;
    logic [2:0]    st_reg, st_next;
    logic          ev_reg, ev_next;
    logic [31:0]   evv_reg, evv_next;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [31:0]   s_wdata, s_rdata;
    logic          v_we;
    logic [31:0]   v_rdata;
    logic [1:0]    rd_phase_reg, rd_phase_next;
    sma_pkg::div_req_t dreq;
    sma_pkg::div_rsp_t drsp;
    logic [VW-1:0] vi_in;
    logic [63:0]   prod;
    logic          slt_ab, slt_ba;

    sma_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    sma_ram #(.WIDTH(32), .DEPTH(1 << VW)) u_vars (
        .clk(clk), .we(v_we), .waddr(vi_reg), .wdata(b_reg),
        .raddr(vi_next), .rdata(v_rdata)
    );

    sma_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // slot index folded into range; a 16-entry constant table
    function automatic logic [VW-1:0] slot_of(input logic [3:0] idx);
        logic [VW-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (idx == 4'(i))
                r = VW'(i % VAR_COUNT);
        end
        return r;
    endfunction

    assign vi_in  = slot_of(var_index);
    assign prod   = a_reg * b_reg;
    assign slt_ab = $signed(a_reg) < $signed(b_reg);
    assign slt_ba = $signed(b_reg) < $signed(a_reg);

    function automatic logic [AW-1:0] ad(input logic [CW-1:0] n, input logic [CW-1:0] k);
        logic [CW-1:0] d;
        d = n - k;
        return d[AW-1:0];
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        imm_next      = imm_reg;
        vi_next       = vi_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        def_next      = def_reg;
        done_next     = 1'b0;
        st_next       = st_reg;
        ev_next       = 1'b0;
        evv_next      = 32'd0;
        rd_phase_next = rd_phase_reg;
        s_we          = 1'b0;
        s_waddr       = ad(cnt_reg, CW'(1));
        s_wdata       = 32'd0;
        s_raddr       = ad(cnt_reg, CW'(1));
        v_we          = 1'b0;
        dreq.start    = 1'b0;
        dreq.is_mod   = (op_reg == sma_pkg::OP_MOD);
        dreq.dividend = a_reg;
        dreq.divisor  = b_reg;
        unique case (state_reg)
            sma_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    imm_next  = immediate;
                    vi_next   = vi_in;
                    s_raddr   = ad(cnt_reg, CW'(1));
                    state_next = sma_pkg::S_READ;
                    rd_phase_next = 2'd0;
                end
            end
            sma_pkg::S_READ:
            begin
                // top arrives now; fetch second
                b_next  = s_rdata;
                s_raddr = ad(cnt_reg, CW'(2));
                state_next = sma_pkg::S_READ3;
                rd_phase_next = 2'd0;
            end
            sma_pkg::S_READ3:
            begin
                if (rd_phase_reg == 2'd0)
                begin
                    a_next  = s_rdata;
                    s_raddr = ad(cnt_reg, CW'(3));
                    if (op_reg == sma_pkg::OP_ROT)
                    begin
                        rd_phase_next = 2'd1;
                    end
                    else
                    begin
                        state_next = sma_pkg::S_EXEC;
                    end
                end
                else
                begin
                    c_next = s_rdata;
                    state_next = sma_pkg::S_EXEC;
                end
            end
            sma_pkg::S_EXEC:
            begin
                done_next = 1'b1;
                st_next   = sma_pkg::ST_OK;
                state_next = sma_pkg::S_IDLE;
                unique case (op_reg) inside
                    sma_pkg::OP_PUSH, sma_pkg::OP_FETCH:
                    begin
                        if (op_reg == sma_pkg::OP_FETCH && !def_reg[vi_reg])
                            st_next = sma_pkg::ST_UNDEF;
                        else if (cnt_reg >= CW'(STACK_DEPTH))
                            st_next = sma_pkg::ST_OVER;
                        else
                        begin
                            s_we    = 1'b1;
                            s_waddr = cnt_reg[AW-1:0];
                            s_wdata = (op_reg == sma_pkg::OP_PUSH) ? imm_reg : v_rdata;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
                    sma_pkg::OP_MOD, [sma_pkg::OP_LT:sma_pkg::OP_OR]:
                    begin
                        if (cnt_reg < CW'(2))
                            st_next = sma_pkg::ST_UNDER;
                        else if ((op_reg == sma_pkg::OP_DIV || op_reg == sma_pkg::OP_MOD)
                                 && b_reg == 32'd0)
                            st_next = sma_pkg::ST_DIVZ;
                        else if (op_reg == sma_pkg::OP_DIV || op_reg == sma_pkg::OP_MOD)
                        begin
                            done_next  = 1'b0;
                            dreq.start = 1'b1;
                            state_next = sma_pkg::S_DIV;
                        end
                        else
                        begin
                            s_we    = 1'b1;
                            s_waddr = ad(cnt_reg, CW'(2));
                            case (op_reg)
                                sma_pkg::OP_ADD: s_wdata = a_reg + b_reg;
                                sma_pkg::OP_SUB: s_wdata = a_reg - b_reg;
                                sma_pkg::OP_MUL: s_wdata = prod[31:0];
                                sma_pkg::OP_LT:  s_wdata = {31'd0, slt_ab};
                                sma_pkg::OP_LE:  s_wdata = {31'd0, !slt_ba};
                                sma_pkg::OP_GT:  s_wdata = {31'd0, slt_ba};
                                sma_pkg::OP_GE:  s_wdata = {31'd0, !slt_ab};
                                sma_pkg::OP_EQ:  s_wdata = {31'd0, a_reg == b_reg};
                                sma_pkg::OP_NE:  s_wdata = {31'd0, a_reg != b_reg};
                                sma_pkg::OP_AND: s_wdata = {31'd0, a_reg != 0 && b_reg != 0};
                                default:         s_wdata = {31'd0, a_reg != 0 || b_reg != 0};
                            endcase
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                    sma_pkg::OP_NEG, sma_pkg::OP_NOT:
                    begin
                        if (cnt_reg < CW'(1))
                            st_next = sma_pkg::ST_UNDER;
                        else
                        begin
                            s_we    = 1'b1;
                            s_wdata = (op_reg == sma_pkg::OP_NEG) ? 32'd0 - b_reg
                                                                  : {31'd0, b_reg == 32'd0};
                        end
                    end
                    sma_pkg::OP_EMIT:
                    begin
                        if (cnt_reg < CW'(1))
                            st_next = sma_pkg::ST_UNDER;
                        else
                        begin
                            ev_next  = 1'b1;
                            evv_next = b_reg;
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                    sma_pkg::OP_DUP:
                    begin
                        if (cnt_reg < CW'(1))
                            st_next = sma_pkg::ST_UNDER;
                        else if (cnt_reg >= CW'(STACK_DEPTH))
                            st_next = sma_pkg::ST_OVER;
                        else
                        begin
                            s_we    = 1'b1;
                            s_waddr = cnt_reg[AW-1:0];
                            s_wdata = b_reg;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    sma_pkg::OP_DROP:
                    begin
                        if (cnt_reg < CW'(1))
                            st_next = sma_pkg::ST_UNDER;
                        else
                            cnt_next = cnt_reg - CW'(1);
                    end
                    sma_pkg::OP_SWAP:
                    begin
                        if (cnt_reg < CW'(2))
                            st_next = sma_pkg::ST_UNDER;
                        else
                        begin
                            s_we      = 1'b1;
                            s_wdata   = a_reg;
                            done_next = 1'b0;
                            state_next = sma_pkg::S_WRITE2;
                        end
                    end
                    sma_pkg::OP_ROT:
                    begin
                        if (cnt_reg < CW'(3))
                            st_next = sma_pkg::ST_UNDER;
                        else
                        begin
                            s_we      = 1'b1;
                            s_wdata   = c_reg;
                            done_next = 1'b0;
                            state_next = sma_pkg::S_WRITE2;
                        end
                    end
                    sma_pkg::OP_DEFINE, sma_pkg::OP_STORE:
                    begin
                        if (cnt_reg < CW'(1))
                            st_next = sma_pkg::ST_UNDER;
                        else if (op_reg == sma_pkg::OP_DEFINE && def_reg[vi_reg])
                            st_next = sma_pkg::ST_DEFINED;
                        else if (op_reg == sma_pkg::OP_STORE && !def_reg[vi_reg])
                            st_next = sma_pkg::ST_UNDEF;
                        else
                        begin
                            v_we = 1'b1;
                            def_next[vi_reg] = 1'b1;
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            sma_pkg::S_DIV:
            begin
                if (drsp.done)
                begin
                    s_we     = 1'b1;
                    s_waddr  = ad(cnt_reg, CW'(2));
                    s_wdata  = drsp.result;
                    cnt_next = cnt_reg - CW'(1);
                    st_next  = sma_pkg::ST_OK;
                    done_next = 1'b1;
                    state_next = sma_pkg::S_IDLE;
                end
            end
            sma_pkg::S_WRITE2:
            begin
                s_we    = 1'b1;
                s_waddr = ad(cnt_reg, CW'(2));
                if (op_reg == sma_pkg::OP_SWAP)
                begin
                    s_wdata   = b_reg;
                    done_next = 1'b1;
                    st_next   = sma_pkg::ST_OK;
                    state_next = sma_pkg::S_IDLE;
                end
                else
                begin
                    s_wdata    = b_reg;
                    state_next = sma_pkg::S_WRITE3;
                end
            end
            sma_pkg::S_WRITE3:
            begin
                s_we      = 1'b1;
                s_waddr   = ad(cnt_reg, CW'(3));
                s_wdata   = a_reg;
                done_next = 1'b1;
                st_next   = sma_pkg::ST_OK;
                state_next = sma_pkg::S_IDLE;
            end
            default: state_next = sma_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sma_pkg::S_IDLE;
            cnt_reg      <= '0;
            def_reg      <= '0;
            done_reg     <= 1'b0;
            rd_phase_reg <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            def_reg      <= def_next;
            done_reg     <= done_next;
            rd_phase_reg <= rd_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        imm_reg <= imm_next;
        vi_reg  <= vi_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        st_reg  <= st_next;
        ev_reg  <= ev_next;
        evv_reg <= evv_next;
    end

    assign busy        = (state_reg != sma_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = st_reg;
    assign emit_valid  = ev_reg;
    assign emit_value  = evv_reg;
    assign stack_depth = 7'(cnt_reg);

endmodule

[tb/tb_stack_machine_alu.sv]
`timescale 1ns / 1ps

module tb_stack_machine_alu;

    localparam int DEPTH = 64;
    localparam int NVARS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int EXP_SLOTS = 16;

    typedef struct {
        logic [2:0]  status;
        logic        emit_valid;
        logic [31:0] emit_value;
        logic [6:0]  stack_depth;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [4:0]         opcode;
    logic signed [31:0] immediate;
    logic [3:0]         var_index;
    logic               done;
    logic [2:0]         status;
    logic               emit_valid;
    logic signed [31:0] emit_value;
    logic [6:0]         stack_depth;

    stack_machine_alu #(.STACK_DEPTH(DEPTH), .VAR_COUNT(NVARS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .immediate(immediate), .var_index(var_index),
        .done(done), .status(status), .emit_valid(emit_valid),
        .emit_value(emit_value), .stack_depth(stack_depth)
    );

    // predictor state
    logic [31:0] mdl_stack [DEPTH];
    int          mdl_count;
    logic [31:0] mdl_vars [NVARS];
    logic        mdl_defined [NVARS];

    // expected results, ring of slots: written by the sender, read by the checker
    outcome_t exp_ring [EXP_SLOTS];
    int       exp_wr = 0;
    int       exp_rd = 0;
    int       errors;
    int       items_sent;
    int       results_seen;
    int       emits_seen;
    longint   cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] magnitude(logic [31:0] a);
        return a[31] ? (32'd0 - a) : a;
    endfunction

    function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // returns 0 on zero divisor
    function automatic logic binary_result(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                           output logic [31:0] r);
        logic [31:0] q;
        r = '0;
        case (op)
            sma_pkg::OP_ADD: r = a + b;
            sma_pkg::OP_SUB: r = a - b;
            sma_pkg::OP_MUL: r = a * b;
            sma_pkg::OP_DIV:
            begin
                if (b == 0) return 1'b0;
                q = magnitude(a) / magnitude(b);
                r = (a[31] ^ b[31]) ? (32'd0 - q) : q;
            end
            sma_pkg::OP_MOD:
            begin
                if (b == 0) return 1'b0;
                q = magnitude(a) % magnitude(b);
                r = a[31] ? (32'd0 - q) : q;
            end
            sma_pkg::OP_LT:  r = signed_lt(a, b) ? 32'd1 : 32'd0;
            sma_pkg::OP_LE:  r = signed_lt(b, a) ? 32'd0 : 32'd1;
            sma_pkg::OP_GT:  r = signed_lt(b, a) ? 32'd1 : 32'd0;
            sma_pkg::OP_GE:  r = signed_lt(a, b) ? 32'd0 : 32'd1;
            sma_pkg::OP_EQ:  r = (a == b) ? 32'd1 : 32'd0;
            sma_pkg::OP_NE:  r = (a != b) ? 32'd1 : 32'd0;
            sma_pkg::OP_AND: r = (a != 0 && b != 0) ? 32'd1 : 32'd0;
            default: r = (a != 0 || b != 0) ? 32'd1 : 32'd0;
        endcase
        return 1'b1;
    endfunction

    function automatic outcome_t execute_op(logic [4:0] op, logic [31:0] imm, logic [3:0] vi);
        outcome_t o;
        int n;
        logic [31:0] r;
        logic [31:0] t;
        n = mdl_count;
        o.status = sma_pkg::ST_OK;
        o.emit_valid = 1'b0;
        o.emit_value = '0;
        case (op)
            sma_pkg::OP_PUSH:
                if (n >= DEPTH) o.status = sma_pkg::ST_OVER;
                else
                begin
                    mdl_stack[n] = imm;
                    n++;
                end
            sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
            sma_pkg::OP_MOD, sma_pkg::OP_LT, sma_pkg::OP_LE, sma_pkg::OP_GT,
            sma_pkg::OP_GE, sma_pkg::OP_EQ, sma_pkg::OP_NE, sma_pkg::OP_AND,
            sma_pkg::OP_OR:
                if (n < 2) o.status = sma_pkg::ST_UNDER;
                else if (!binary_result(op, mdl_stack[n-2], mdl_stack[n-1], r))
                    o.status = sma_pkg::ST_DIVZ;
                else
                begin
                    mdl_stack[n-2] = r;
                    n--;
                end
            sma_pkg::OP_NEG:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else mdl_stack[n-1] = 32'd0 - mdl_stack[n-1];
            sma_pkg::OP_EMIT:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else
                begin
                    o.emit_valid = 1'b1;
                    o.emit_value = mdl_stack[n-1];
                    n--;
                end
            sma_pkg::OP_DUP:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else if (n >= DEPTH) o.status = sma_pkg::ST_OVER;
                else
                begin
                    mdl_stack[n] = mdl_stack[n-1];
                    n++;
                end
            sma_pkg::OP_DROP:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else n--;
            sma_pkg::OP_SWAP:
                if (n < 2) o.status = sma_pkg::ST_UNDER;
                else
                begin
                    t = mdl_stack[n-1];
                    mdl_stack[n-1] = mdl_stack[n-2];
                    mdl_stack[n-2] = t;
                end
            sma_pkg::OP_ROT:
                if (n < 3) o.status = sma_pkg::ST_UNDER;
                else
                begin
                    t = mdl_stack[n-3];
                    mdl_stack[n-3] = mdl_stack[n-2];
                    mdl_stack[n-2] = mdl_stack[n-1];
                    mdl_stack[n-1] = t;
                end
            sma_pkg::OP_NOT:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else mdl_stack[n-1] = (mdl_stack[n-1] != 0) ? 32'd0 : 32'd1;
            sma_pkg::OP_DEFINE:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else if (mdl_defined[vi]) o.status = sma_pkg::ST_DEFINED;
                else
                begin
                    mdl_vars[vi] = mdl_stack[n-1];
                    mdl_defined[vi] = 1'b1;
                    n--;
                end
            sma_pkg::OP_FETCH:
                if (!mdl_defined[vi]) o.status = sma_pkg::ST_UNDEF;
                else if (n >= DEPTH) o.status = sma_pkg::ST_OVER;
                else
                begin
                    mdl_stack[n] = mdl_vars[vi];
                    n++;
                end
            sma_pkg::OP_STORE:
                if (n < 1) o.status = sma_pkg::ST_UNDER;
                else if (!mdl_defined[vi]) o.status = sma_pkg::ST_UNDEF;
                else
                begin
                    mdl_vars[vi] = mdl_stack[n-1];
                    n--;
                end
            default: ;
        endcase
        mdl_count = n;
        o.stack_depth = n[6:0];
        return o;
    endfunction

    // drop start and scramble the payload while nothing is offered
    task automatic go_quiet();
        start     <= 1'b0;
        opcode    <= 5'($urandom());
        immediate <= $urandom();
        var_index <= 4'($urandom());
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return;
        go_quiet();
        if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(8, 40)) @(posedge clk);
    endtask

    task automatic send_op(logic [4:0] op, logic [31:0] imm, logic [3:0] vi,
                           bit gaps = 1'b1);
        if (gaps) idle_gap();
        start     <= 1'b1;
        opcode    <= op;
        immediate <= imm;
        var_index <= vi;
        @(posedge clk);
        while (busy) @(posedge clk);
        exp_ring[exp_wr % EXP_SLOTS] = execute_op(op, imm, vi);
        exp_wr++;
        items_sent++;
    endtask

    task automatic wait_drained();
        go_quiet();
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (emit_valid) emits_seen++;
            if (exp_wr == exp_rd)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = exp_ring[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (emit_valid !== e.emit_valid)
                begin
                    $error("emit_valid expected %0d actual %0d", e.emit_valid, emit_valid);
                    errors++;
                end
                if (emit_value !== e.emit_value)
                begin
                    $error("emit_value expected %h actual %h", e.emit_value, emit_value);
                    errors++;
                end
                if (stack_depth !== e.stack_depth)
                begin
                    $error("stack_depth expected %0d actual %0d", e.stack_depth, stack_depth);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'd1;
            5: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_underflow_on_empty();
        for (int op = 1; op <= 31; op++)
            send_op(5'(op), pick_value(), 4'($urandom()));
    endtask

    task automatic test_arith_edges();
        send_op(sma_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_op(sma_pkg::OP_PUSH, 32'hffff_ffff, 0);
        send_op(sma_pkg::OP_DIV, 0, 0);
        send_op(sma_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_op(sma_pkg::OP_PUSH, 32'hffff_ffff, 0);
        send_op(sma_pkg::OP_MOD, 0, 0);
        send_op(sma_pkg::OP_PUSH, 32'h0, 0);
        send_op(sma_pkg::OP_DIV, 0, 0);
        send_op(sma_pkg::OP_MOD, 0, 0);
        send_op(sma_pkg::OP_NEG, 0, 0);
        send_op(sma_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_op(sma_pkg::OP_NEG, 0, 0);
        send_op(sma_pkg::OP_PUSH, 32'h7fff_ffff, 0);
        send_op(sma_pkg::OP_ROT, 0, 0);
        send_op(sma_pkg::OP_SWAP, 0, 0);
        send_op(sma_pkg::OP_MUL, 0, 0);
        send_op(sma_pkg::OP_NOT, 0, 0);
        send_op(sma_pkg::OP_EMIT, 0, 0);
        send_op(sma_pkg::OP_EMIT, 0, 0);
        send_op(sma_pkg::OP_EMIT, 0, 0);
        send_op(sma_pkg::OP_EMIT, 0, 0);
    endtask

    task automatic test_variables();
        send_op(sma_pkg::OP_FETCH, 0, 4'd15);
        send_op(sma_pkg::OP_PUSH, 32'h1234_5678, 0);
        send_op(sma_pkg::OP_STORE, 0, 4'd15);
        send_op(sma_pkg::OP_DEFINE, 0, 4'd15);
        send_op(sma_pkg::OP_PUSH, 32'hdead_beef, 0);
        send_op(sma_pkg::OP_DEFINE, 0, 4'd15);
        send_op(sma_pkg::OP_FETCH, 0, 4'd15);
        send_op(sma_pkg::OP_STORE, 0, 4'd15);
        send_op(sma_pkg::OP_FETCH, 0, 4'd15);
        send_op(sma_pkg::OP_EMIT, 0, 0);
        send_op(sma_pkg::OP_EMIT, 0, 0);
    endtask

    // fill to the top, probe overflow on push/dup/fetch, then drain
    task automatic test_full_stack();
        while (mdl_count < DEPTH) send_op(sma_pkg::OP_PUSH, pick_value(), 0, 1'b0);
        send_op(sma_pkg::OP_PUSH, 32'h5555_aaaa, 0);
        send_op(sma_pkg::OP_DUP, 0, 0);
        send_op(sma_pkg::OP_FETCH, 0, 4'd15);
        send_op(sma_pkg::OP_FETCH, 0, 4'd3);
        while (mdl_count > 0) send_op(sma_pkg::OP_EMIT, 0, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_programs(int count);
        int r;
        logic [4:0] op;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3) op = 5'($urandom_range(24, 31));
            else if (mdl_count < 2 || (r < 25 && mdl_count < DEPTH - 2)) op = sma_pkg::OP_PUSH;
            else op = 5'($urandom_range(1, 23));
            send_op(op, pick_value(), 4'($urandom()));
            if (i == count / 2) wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = '0;
        immediate = '0;
        var_index = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        emits_seen = 0;
        mdl_count = 0;
        for (int i = 0; i < NVARS; i++) mdl_defined[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_underflow_on_empty();
        test_arith_edges();
        test_variables();
        test_full_stack();
        test_random_programs(800);
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Ran %0d operations, %0d results checked, %0d emits, incl. full-stack",
                 items_sent, results_seen, emits_seen);
        $display("and underflow, divide-by-zero and variable fault cases.");
        if (errors == 0 && exp_wr == exp_rd)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
